// ===== hw/rtl/psc_pkg.sv =====
// -----------------------------------------------------------------------------
// psc_pkg
// Shared constants, register codes and types of the pot sample conditioner.
// -----------------------------------------------------------------------------
package psc_pkg;

   // Default datapath geometry
   localparam int DEF_SAMPLE_BITS   = 12;
   localparam int DEF_FRACTION_BITS = 8;

   // Control/status register port geometry
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Register field widths
   localparam int RAIL_SNAP_W = 11;
   localparam int DEADZONE_W  = 12;
   localparam int BLEND_W     = 9;
   localparam int THRESHOLD_W = 12;

   // Blend weights are in units of 1/2^BLEND_SHIFT
   localparam int BLEND_SHIFT = 8;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_RAIL_SNAP      = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEADZONE       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLEND          = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEND_THRESHOLD = 2'd3;

   // Register reset values
   localparam logic [RAIL_SNAP_W-1:0] RAIL_SNAP_RESET = 11'd15;
   localparam logic [DEADZONE_W-1:0]  DEADZONE_RESET  = 12'd10;
   localparam logic [BLEND_W-1:0]     BLEND_RESET     = 9'd128;
   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 12'd10;
   localparam logic [BLEND_W-1:0]     BLEND_FULL      = 9'd256;

   // Request kinds
   localparam logic REQ_INIT   = 1'b0;
   localparam logic REQ_FILTER = 1'b1;

   // Live register settings handed to the filter core
   typedef struct packed {
      logic [RAIL_SNAP_W-1:0] rail_snap;
      logic [DEADZONE_W-1:0]  deadzone;
      logic [BLEND_W-1:0]     blend;
      logic [THRESHOLD_W-1:0] send_threshold;
   } psc_cfg_type;

endpackage

// ===== hw/rtl/psc_req_if.sv =====
// -----------------------------------------------------------------------------
// psc_req_if
// Request channel: one raw converter sample and its request kind per item.
// -----------------------------------------------------------------------------
interface psc_req_if
   import psc_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output req_type, output sample, input ready);
   modport sink   (input valid, input req_type, input sample, output ready);
endinterface

// ===== hw/rtl/psc_rsp_if.sv =====
// -----------------------------------------------------------------------------
// psc_rsp_if
// Response channel: stable value and send flag per item.
// -----------------------------------------------------------------------------
interface psc_rsp_if
   import psc_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] stable_value;
   logic                   send_now;

   modport source (output valid, output stable_value, output send_now, input ready);
   modport sink   (input valid, input stable_value, input send_now, output ready);
endinterface

// ===== hw/rtl/pot_sample_conditioner_top.sv =====
// -----------------------------------------------------------------------------
// pot_sample_conditioner_top
// Deadzone and moving-average conditioner for potentiometer samples.
// -----------------------------------------------------------------------------
// Usage:
//   req_port carries one item per sample: req_type (0 loads the filter from
//   the sample, 1 filters it) and the raw sample. rsp_port returns one item
//   per request: the stable value and the send flag.
//   The csr_ port writes rail_snap, deadzone, blend and send_threshold by
//   index; write only while no item is in flight.
//   An item taken on req_port is registered in the input stage, and its
//   result is registered in the result register that drives rsp_port.
//   Throughput: one item per cycle while rsp_port is not held. The snap,
//   deadzone test, one blend multiply and the send compare sit in one
//   combinational pass between the input register and the result
//   register, closing the filter state loop.
//   Stall: while rsp_port is held, the result register keeps its item and
//   one more item waits in the input register; req_port ready then drops.
//   Reset (synchronous): empties both stages, clears the estimate and the
//   stable value, marks nothing as sent and loads register defaults.
// -----------------------------------------------------------------------------
module pot_sample_conditioner_top
   import psc_pkg::*;
#(
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   psc_req_if.sink                req_port,
   psc_rsp_if.source              rsp_port,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   psc_cfg_type cfg;

   // Input stage
   logic                   in_valid_ff, in_valid_in;
   logic                   in_req_ff;
   logic [SAMPLE_BITS-1:0] in_sample_ff;

   // Result stage
   logic                   out_valid_ff, out_valid_in;
   logic [SAMPLE_BITS-1:0] out_stable_ff;
   logic                   out_send_ff;

   logic                   out_free, step, in_free, take;
   logic [SAMPLE_BITS-1:0] core_stable;
   logic                   core_send;

   psc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   psc_core #(
      .SAMPLE_BITS   (SAMPLE_BITS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .req_type     (in_req_ff),
      .sample       (in_sample_ff),
      .cfg          (cfg),
      .stable_value (core_stable),
      .send_now     (core_send)
   );

   // Advance when the result register is free or being drained
   always_comb begin
      out_free     = !out_valid_ff || rsp_port.ready;
      step         = in_valid_ff && out_free;
      in_free      = !in_valid_ff || step;
      take         = req_port.valid && in_free;
      in_valid_in  = take || (in_valid_ff && !step);
      out_valid_in = step || (out_valid_ff && !rsp_port.ready);
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture the incoming item
   always_ff @(posedge clock) begin
      if (take) begin
         in_req_ff    <= req_port.req_type;
         in_sample_ff <= req_port.sample;
      end
   end

   // Capture the result item
   always_ff @(posedge clock) begin
      if (step) begin
         out_stable_ff <= core_stable;
         out_send_ff   <= core_send;
      end
   end

   assign req_port.ready        = in_free;
   assign rsp_port.valid        = out_valid_ff;
   assign rsp_port.stable_value = out_stable_ff;
   assign rsp_port.send_now     = out_send_ff;

endmodule

// ===== hw/rtl/psc_csr.sv =====
// -----------------------------------------------------------------------------
// psc_csr
// Configuration registers of the conditioner, written through a plain port.
// -----------------------------------------------------------------------------
module psc_csr
   import psc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data,
   output psc_cfg_type            cfg
);

   logic [RAIL_SNAP_W-1:0] rail_snap_ff, rail_snap_in;
   logic [DEADZONE_W-1:0]  deadzone_ff, deadzone_in;
   logic [BLEND_W-1:0]     blend_ff, blend_in;
   logic [THRESHOLD_W-1:0] threshold_ff, threshold_in;
   logic [BLEND_W-1:0]     blend_wr;

   // Saturate the blend weight at full scale
   always_comb begin
      blend_wr = csr_write_data[BLEND_W-1:0];
      if (blend_wr > BLEND_FULL) begin
         blend_wr = BLEND_FULL;
      end
   end

   // Decode the register write
   always_comb begin
      rail_snap_in = rail_snap_ff;
      deadzone_in  = deadzone_ff;
      blend_in     = blend_ff;
      threshold_in = threshold_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_RAIL_SNAP:      rail_snap_in = csr_write_data[RAIL_SNAP_W-1:0];
            CSR_DEADZONE:       deadzone_in  = csr_write_data[DEADZONE_W-1:0];
            CSR_BLEND:          blend_in     = blend_wr;
            CSR_SEND_THRESHOLD: threshold_in = csr_write_data[THRESHOLD_W-1:0];
            default:            ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rail_snap_ff <= RAIL_SNAP_RESET;
         deadzone_ff  <= DEADZONE_RESET;
         blend_ff     <= BLEND_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         rail_snap_ff <= rail_snap_in;
         deadzone_ff  <= deadzone_in;
         blend_ff     <= blend_in;
         threshold_ff <= threshold_in;
      end
   end

   assign cfg.rail_snap      = rail_snap_ff;
   assign cfg.deadzone       = deadzone_ff;
   assign cfg.blend          = blend_ff;
   assign cfg.send_threshold = threshold_ff;

endmodule

// ===== hw/rtl/psc_core.sv =====
// -----------------------------------------------------------------------------
// psc_core
// Filter state and the single-pass snap, deadzone, blend and send decision.
// -----------------------------------------------------------------------------
module psc_core
   import psc_pkg::*;
#(
   parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
   parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   req_type,
   input  logic [SAMPLE_BITS-1:0] sample,
   input  psc_cfg_type            cfg,
   output logic [SAMPLE_BITS-1:0] stable_value,
   output logic                   send_now
);

   localparam int EST_W = SAMPLE_BITS + FRACTION_BITS;
   localparam int CMP_W = ((SAMPLE_BITS > CSR_DATA_W) ? SAMPLE_BITS : CSR_DATA_W) + 2;
   localparam int SUM_W = EST_W + BLEND_W + 3;
   localparam logic [SAMPLE_BITS-1:0] TOP_CODE = '1;
   localparam logic [EST_W:0] HALF_LSB = {{EST_W{1'b0}}, 1'b1} << (FRACTION_BITS - 1);
   localparam logic [SUM_W-1:0] HALF_BLEND = {{(SUM_W-1){1'b0}}, 1'b1} << (BLEND_SHIFT - 1);

   // Filter state
   logic [EST_W-1:0]              est_ff, est_in;
   logic [SAMPLE_BITS-1:0]        stable_ff, stable_in;
   logic signed [SAMPLE_BITS:0]   last_ff, last_in;

   logic signed [CMP_W-1:0] raw_s, top_s, edge_s, high_edge_s, snap_s;
   logic signed [CMP_W-1:0] stable_s, dz_s, thr_s, last_s, new_s;
   logic signed [CMP_W-1:0] dz_diff, send_diff;
   logic                    update, send;
   logic [EST_W-1:0]        target;
   logic signed [EST_W+1:0] delta;
   logic signed [SUM_W-1:0] prod, sum;
   logic [EST_W-1:0]        blend_est;
   logic [EST_W:0]          rnd_sum;
   logic [SAMPLE_BITS:0]    rnd;
   logic [SAMPLE_BITS-1:0]  blend_stable, stable_next;

   // Snap the sample to either end of the range, low end first
   always_comb begin
      raw_s    = signed'({{(CMP_W-SAMPLE_BITS){1'b0}}, sample});
      top_s    = signed'({{(CMP_W-SAMPLE_BITS){1'b0}}, TOP_CODE});
      edge_s   = signed'({{(CMP_W-RAIL_SNAP_W){1'b0}}, cfg.rail_snap});
      dz_s     = signed'({{(CMP_W-DEADZONE_W){1'b0}}, cfg.deadzone});
      thr_s    = signed'({{(CMP_W-THRESHOLD_W){1'b0}}, cfg.send_threshold});
      stable_s = signed'({{(CMP_W-SAMPLE_BITS){1'b0}}, stable_ff});
      last_s   = {{(CMP_W-SAMPLE_BITS-1){last_ff[SAMPLE_BITS]}}, last_ff};
      high_edge_s = top_s - edge_s;
      if (high_edge_s < 0) begin
         high_edge_s = '0;
      end
      snap_s = raw_s;
      if (snap_s <= edge_s) begin
         snap_s = '0;
      end
      if (snap_s >= high_edge_s) begin
         snap_s = top_s;
      end
   end

   // Deadzone test against the stable value
   always_comb begin
      dz_diff = (snap_s > stable_s) ? (snap_s - stable_s) : (stable_s - snap_s);
      update  = (dz_diff >= dz_s);
   end

   // Blend step: est + blend*(target - est)/256, rounded half up
   always_comb begin
      target    = {snap_s[SAMPLE_BITS-1:0], {FRACTION_BITS{1'b0}}};
      delta     = signed'({2'b00, target}) - signed'({2'b00, est_ff});
      prod      = signed'({{(SUM_W-BLEND_W){1'b0}}, cfg.blend})
                * signed'({{(SUM_W-EST_W-2){delta[EST_W+1]}}, delta});
      sum       = (signed'({{(SUM_W-EST_W){1'b0}}, est_ff}) <<< BLEND_SHIFT) + prod
                + signed'(HALF_BLEND);
      blend_est = sum[EST_W+BLEND_SHIFT-1:BLEND_SHIFT];
      rnd_sum   = {1'b0, blend_est} + HALF_LSB;
      rnd       = rnd_sum[EST_W:FRACTION_BITS];
      if (rnd > {1'b0, TOP_CODE}) begin
         blend_stable = TOP_CODE;
      end else begin
         blend_stable = rnd[SAMPLE_BITS-1:0];
      end
      stable_next = update ? blend_stable : stable_ff;
   end

   // Send decision against the last sent value
   always_comb begin
      new_s     = signed'({{(CMP_W-SAMPLE_BITS){1'b0}}, stable_next});
      send_diff = (new_s > last_s) ? (new_s - last_s) : (last_s - new_s);
      send      = (send_diff >= thr_s);
   end

   // Next state for either request kind
   always_comb begin
      est_in    = est_ff;
      stable_in = stable_ff;
      last_in   = last_ff;
      if (req_type == REQ_INIT) begin
         est_in    = {sample, {FRACTION_BITS{1'b0}}};
         stable_in = sample;
      end else begin
         if (update) begin
            est_in = blend_est;
         end
         stable_in = stable_next;
         if (send) begin
            last_in = signed'({1'b0, stable_next});
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff    <= '0;
         stable_ff <= '0;
         last_ff   <= '1;
      end else if (step) begin
         est_ff    <= est_in;
         stable_ff <= stable_in;
         last_ff   <= last_in;
      end
   end

   assign stable_value = stable_in;
   assign send_now     = (req_type == REQ_FILTER) && send;

endmodule
